[rtl/dcr_pkg.sv]
// Shared types, constants and binary32 arithmetic helpers for the distance
// constraint relaxation pipeline. Depends on nothing.
package dcr_pkg;

  localparam logic [31:0] MAGIC    = 32'h5f3759df;
  localparam logic [31:0] F_HALF   = 32'h3f000000;
  localparam logic [31:0] F_THREEH = 32'h3fc00000;
  localparam logic [31:0] F_MIN_SQ = 32'h38d1b717;  // 0.0001
  localparam logic [31:0] F_DEFNAN = 32'hffc00000;
  localparam logic [31:0] F_QBIT   = 32'h00400000;

  localparam int FRONT_STAGES = 5;
  localparam int RSQ_STAGES   = 4;
  localparam int APPLY_STAGES = 7;

  typedef struct packed {
    logic [5:0][31:0] pos;   // first xyz in 0..2, second xyz in 3..5
    logic [31:0]      rest;
    logic [31:0]      gain;
    logic             live;
    logic             skip;
    logic [2:0][31:0] dlt;
    logic [2:0][31:0] sq;
    logic [31:0]      s;
    logic [31:0]      h;
    logic [31:0]      y0;
    logic [31:0]      t;
    logic [31:0]      r;
    logic [31:0]      w;
  } pipe_t;

  function automatic logic is_nan(logic [31:0] a);
    return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] a);
    return (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
  endfunction

  // value = m * 2^e, rounded to nearest even with gradual underflow
  function automatic logic [31:0] round_pack(logic sgn, int e, logic [63:0] m);
    int          l;
    int          be;
    int          sh;
    logic [63:0] q;
    logic        g;
    logic        st;
    logic [31:0] res;
    l = 0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) l = i;
    end
    be = l + e + 127;
    sh = (be >= 1) ? (l - 23) : (-149 - e);
    g  = 1'b0;
    st = 1'b0;
    if (sh > 64) begin
      q  = 64'd0;
      st = |m;
    end else if (sh > 0) begin
      q  = m >> sh;
      g  = m[6'(sh - 1)];
      st = |(m & ((64'd1 << (sh - 1)) - 64'd1));
    end else begin
      q = m << (-sh);
    end
    q = q + {63'd0, g & (st | q[0])};
    if (m == 64'd0) begin
      res = {sgn, 31'd0};
    end else if (be >= 1) begin
      if (q[24]) begin
        q  = q >> 1;
        be = be + 1;
      end
      if (be >= 255) res = {sgn, 8'hff, 23'd0};
      else           res = {sgn, 8'(be), q[22:0]};
    end else begin
      res = {sgn, 7'd0, q[23], q[22:0]};
    end
    return res;
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic        sg;
    logic [23:0] ma;
    logic [23:0] mb;
    int          ea;
    int          eb;
    logic [31:0] res;
    sg = a[31] ^ b[31];
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
    eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
    if (is_nan(a))      res = a | F_QBIT;
    else if (is_nan(b)) res = b | F_QBIT;
    else if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
      res = F_DEFNAN;
    else if (is_inf(a) || is_inf(b)) res = {sg, 8'hff, 23'd0};
    else res = round_pack(sg, ea + eb - 300, {40'd0, ma} * {40'd0, mb});
    return res;
  endfunction

  // a + b, or a - b when sub is set
  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b, logic sub);
    logic [31:0] bb;
    logic [31:0] x;
    logic [31:0] y;
    int          ex;
    int          ey;
    int          de;
    logic [63:0] mx;
    logic [63:0] my;
    logic [63:0] ys;
    logic [63:0] m;
    logic [31:0] res;
    bb = {b[31] ^ sub, b[30:0]};
    if (a[30:0] < bb[30:0]) begin
      x = bb;
      y = a;
    end else begin
      x = a;
      y = bb;
    end
    ex = (x[30:23] == 8'd0) ? 1 : int'(x[30:23]);
    ey = (y[30:23] == 8'd0) ? 1 : int'(y[30:23]);
    de = ex - ey;
    mx = {40'd0, (x[30:23] != 8'd0), x[22:0]} << 26;
    my = {40'd0, (y[30:23] != 8'd0), y[22:0]} << 26;
    if (de >= 50) ys = {63'd0, |my};
    else          ys = (my >> de) | {63'd0, |(my & ((64'd1 << de) - 64'd1))};
    m = (x[31] == y[31]) ? (mx + ys) : (mx - ys);
    if (is_nan(a))      res = a | F_QBIT;
    else if (is_nan(b)) res = b | F_QBIT;
    else if (is_inf(a) && is_inf(bb) && (a[31] != bb[31])) res = F_DEFNAN;
    else if (is_inf(a))  res = a;
    else if (is_inf(bb)) res = bb;
    else if (m == 64'd0) res = {(x[31] == y[31]) ? x[31] : 1'b0, 31'd0};
    else res = round_pack(x[31], ex - 176, m);
    return res;
  endfunction

  // ordered a < b for a non-negative constant b
  function automatic logic fp_lt_pos(logic [31:0] a, logic [31:0] b);
    logic res;
    if (is_nan(a))  res = 1'b0;
    else if (a[31]) res = 1'b1;
    else            res = a[30:0] < b[30:0];
    return res;
  endfunction

endpackage

[rtl/dcr_in_if.sv]
// Request channel of the constraint relaxation block: valid, ready, payload.
// Depends on nothing.
interface dcr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_x;
  logic [31:0] first_y;
  logic [31:0] first_z;
  logic [31:0] second_x;
  logic [31:0] second_y;
  logic [31:0] second_z;
  logic [31:0] rest_len;
  logic [31:0] spring_gain;
  logic        both_live;
  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  rest_len, spring_gain, both_live, input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                rest_len, spring_gain, both_live, output ready);
endinterface

[rtl/dcr_out_if.sv]
// Result channel of the constraint relaxation block: valid, ready, payload.
// Depends on nothing.
interface dcr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_first_x;
  logic [31:0] new_first_y;
  logic [31:0] new_first_z;
  logic [31:0] new_second_x;
  logic [31:0] new_second_y;
  logic [31:0] new_second_z;
  logic        applied;
  modport source (output valid, new_first_x, new_first_y, new_first_z, new_second_x,
                  new_second_y, new_second_z, applied, input ready);
  modport sink (input valid, new_first_x, new_first_y, new_first_z, new_second_x,
                new_second_y, new_second_z, applied, output ready);
endinterface

[rtl/distance_constraint_relax_top.sv]
// One relaxation step of a spring distance constraint in binary32. Takes one
// request per cycle while the pipeline is not held; one binary32 operation per
// pipeline stage (5 geometry, 4 inverse root, 7 apply), passed in that order.
// The whole pipeline advances together: it holds while the final result waits
// and ready is low, and ready to the request side is the pipeline enable.
// Inactive or too-close requests pass positions through with applied clear.
// Depends on dcr_pkg, dcr_in_if, dcr_out_if, dcr_front, dcr_rsqrt, dcr_apply.
module distance_constraint_relax_top (
  input  logic     clk,
  input  logic     rst,
  dcr_in_if.sink   request,
  dcr_out_if.source result
);
  logic           en;
  logic           v_front;
  logic           v_rsq;
  logic           v_out;
  dcr_pkg::pipe_t p_in;
  dcr_pkg::pipe_t p_front;
  dcr_pkg::pipe_t p_rsq;
  dcr_pkg::pipe_t p_out;

  // advance when the last stage is empty or its result is being taken
  assign en            = !v_out || result.ready;
  assign request.ready = en;

  always_comb begin
    p_in        = '0;
    p_in.pos[0] = request.first_x;
    p_in.pos[1] = request.first_y;
    p_in.pos[2] = request.first_z;
    p_in.pos[3] = request.second_x;
    p_in.pos[4] = request.second_y;
    p_in.pos[5] = request.second_z;
    p_in.rest   = request.rest_len;
    p_in.gain   = request.spring_gain;
    p_in.live   = request.both_live;
  end

  dcr_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .vin(request.valid), .din(p_in), .vout(v_front), .dout(p_front)
  );

  dcr_rsqrt u_rsqrt (
    .clk(clk), .rst(rst), .en(en),
    .vin(v_front), .din(p_front), .vout(v_rsq), .dout(p_rsq)
  );

  dcr_apply u_apply (
    .clk(clk), .rst(rst), .en(en),
    .vin(v_rsq), .din(p_rsq), .vout(v_out), .dout(p_out)
  );

  assign result.valid        = v_out;
  assign result.new_first_x  = p_out.pos[0];
  assign result.new_first_y  = p_out.pos[1];
  assign result.new_first_z  = p_out.pos[2];
  assign result.new_second_x = p_out.pos[3];
  assign result.new_second_y = p_out.pos[4];
  assign result.new_second_z = p_out.pos[5];
  assign result.applied      = !p_out.skip;
endmodule

[rtl/dcr_front.sv]
// Geometry stages: difference, squares, squared distance, seed and skip test.
// Depends on dcr_pkg.
module dcr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  dcr_pkg::pipe_t din,
  output logic          vout,
  output dcr_pkg::pipe_t dout
);
  logic           v [dcr_pkg::FRONT_STAGES];
  dcr_pkg::pipe_t d [dcr_pkg::FRONT_STAGES];
  dcr_pkg::pipe_t d_next [dcr_pkg::FRONT_STAGES];

  always_comb begin
    d_next[0] = din;
    for (int k = 0; k < 3; k++)
      d_next[0].dlt[k] = dcr_pkg::fp_add(din.pos[3 + k], din.pos[k], 1'b1);
    d_next[1] = d[0];
    for (int k = 0; k < 3; k++)
      d_next[1].sq[k] = dcr_pkg::fp_mul(d[0].dlt[k], d[0].dlt[k]);
    d_next[2] = d[1];
    d_next[2].w = dcr_pkg::fp_add(d[1].sq[0], d[1].sq[1], 1'b0);
    d_next[3] = d[2];
    d_next[3].s = dcr_pkg::fp_add(d[2].w, d[2].sq[2], 1'b0);
    d_next[4] = d[3];
    d_next[4].h    = dcr_pkg::fp_mul(d[3].s, dcr_pkg::F_HALF);
    d_next[4].y0   = dcr_pkg::MAGIC - {1'b0, d[3].s[31:1]};
    d_next[4].skip = !d[3].live || dcr_pkg::fp_lt_pos(d[3].s, dcr_pkg::F_MIN_SQ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < dcr_pkg::FRONT_STAGES; k++) v[k] <= 1'b0;
    end else if (en) begin
      v[0] <= vin;
      for (int k = 1; k < dcr_pkg::FRONT_STAGES; k++) v[k] <= v[k - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < dcr_pkg::FRONT_STAGES; k++) d[k] <= d_next[k];
    end
  end

  assign vout = v[dcr_pkg::FRONT_STAGES - 1];
  assign dout = d[dcr_pkg::FRONT_STAGES - 1];
endmodule

[rtl/dcr_rsqrt.sv]
// Inverse square root refinement: one Newton step on the bit-trick seed.
// Depends on dcr_pkg.
module dcr_rsqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  dcr_pkg::pipe_t din,
  output logic          vout,
  output dcr_pkg::pipe_t dout
);
  logic           v [dcr_pkg::RSQ_STAGES];
  dcr_pkg::pipe_t d [dcr_pkg::RSQ_STAGES];
  dcr_pkg::pipe_t d_next [dcr_pkg::RSQ_STAGES];

  always_comb begin
    d_next[0] = din;
    d_next[0].t = dcr_pkg::fp_mul(din.h, din.y0);
    d_next[1] = d[0];
    d_next[1].t = dcr_pkg::fp_mul(d[0].t, d[0].y0);
    d_next[2] = d[1];
    d_next[2].t = dcr_pkg::fp_add(dcr_pkg::F_THREEH, d[1].t, 1'b1);
    d_next[3] = d[2];
    d_next[3].r = dcr_pkg::fp_mul(d[2].y0, d[2].t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < dcr_pkg::RSQ_STAGES; k++) v[k] <= 1'b0;
    end else if (en) begin
      v[0] <= vin;
      for (int k = 1; k < dcr_pkg::RSQ_STAGES; k++) v[k] <= v[k - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < dcr_pkg::RSQ_STAGES; k++) d[k] <= d_next[k];
    end
  end

  assign vout = v[dcr_pkg::RSQ_STAGES - 1];
  assign dout = d[dcr_pkg::RSQ_STAGES - 1];
endmodule

[rtl/dcr_apply.sv]
// Correction stages: length error, scale, offsets and the moved positions.
// Depends on dcr_pkg.
module dcr_apply (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  dcr_pkg::pipe_t din,
  output logic          vout,
  output dcr_pkg::pipe_t dout
);
  logic           v [dcr_pkg::APPLY_STAGES];
  dcr_pkg::pipe_t d [dcr_pkg::APPLY_STAGES];
  dcr_pkg::pipe_t d_next [dcr_pkg::APPLY_STAGES];

  always_comb begin
    d_next[0] = din;
    d_next[0].w = dcr_pkg::fp_mul(din.s, din.r);
    d_next[1] = d[0];
    d_next[1].w = dcr_pkg::fp_add(d[0].rest, d[0].w, 1'b1);
    d_next[2] = d[1];
    d_next[2].w = dcr_pkg::fp_mul(d[1].w, d[1].r);
    d_next[3] = d[2];
    d_next[3].w = dcr_pkg::fp_mul(d[2].w, dcr_pkg::F_HALF);
    d_next[4] = d[3];
    d_next[4].w = dcr_pkg::fp_mul(d[3].w, d[3].gain);
    d_next[5] = d[4];
    for (int k = 0; k < 3; k++)
      d_next[5].sq[k] = dcr_pkg::fp_mul(d[4].dlt[k], d[4].w);
    // skipped items keep their positions bit for bit
    d_next[6] = d[5];
    if (!d[5].skip) begin
      for (int k = 0; k < 3; k++) begin
        d_next[6].pos[k]     = dcr_pkg::fp_add(d[5].pos[k], d[5].sq[k], 1'b1);
        d_next[6].pos[3 + k] = dcr_pkg::fp_add(d[5].pos[3 + k], d[5].sq[k], 1'b0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < dcr_pkg::APPLY_STAGES; k++) v[k] <= 1'b0;
    end else if (en) begin
      v[0] <= vin;
      for (int k = 1; k < dcr_pkg::APPLY_STAGES; k++) v[k] <= v[k - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < dcr_pkg::APPLY_STAGES; k++) d[k] <= d_next[k];
    end
  end

  assign vout = v[dcr_pkg::APPLY_STAGES - 1];
  assign dout = d[dcr_pkg::APPLY_STAGES - 1];
endmodule
